>>> rtl/ntc_pkg.sv
// ----------------------------------------------------------------------------
// NTC thermistor package
// Shared constants, the resistance table and the sequencer states of the
// thermistor sample to temperature converter.
// ----------------------------------------------------------------------------
package ntc_pkg;

    localparam int StoredEntries   = 121;
    localparam int TabIdxW         = 7;
    localparam int EntryW          = 20;
    localparam int CfgW            = 20;
    localparam int AdcW            = 12;
    localparam int TempW           = 15;
    localparam int FracQW          = 7;
    localparam int FracNumW        = EntryW + 8;
    // 10 * series resistance always fits in this many bits.
    localparam int ProdBaseW       = 24;
    localparam int TableEntriesDef = 121;
    localparam int AdcBitsDef      = 12;
    localparam int TempBase        = -2000;
    localparam int CentiPerDegree  = 100;

    localparam logic [CfgW-1:0] SeriesResReset = CfgW'(10000);

    // Thermistor resistance in tenths of an ohm, one entry per degree from -20 C.
    localparam logic [EntryW-1:0] RES_TABLE [StoredEntries] = '{
        20'd978396, 20'd923020, 20'd871124, 20'd822471, 20'd776837, 20'd734018,
        20'd693823, 20'd656077, 20'd620616, 20'd587288, 20'd555953, 20'd526480,
        20'd498747, 20'd472643, 20'd448062, 20'd424906, 20'd403086, 20'd382516,
        20'd363117, 20'd344817, 20'd327547, 20'd311243, 20'd295847, 20'd281301,
        20'd267556, 20'd254562, 20'd242274, 20'd230650, 20'd219650, 20'd209239,
        20'd199380, 20'd190041, 20'd181193, 20'd172807, 20'd164857, 20'd157317,
        20'd150164, 20'd143376, 20'd136933, 20'd130816, 20'd125005, 20'd119485,
        20'd114239, 20'd109252, 20'd104510, 20'd100000, 20'd95709,  20'd91626,
        20'd87738,  20'd84037,  20'd80512,  20'd77154,  20'd73953,  20'd70903,
        20'd67995,  20'd65221,  20'd62576,  20'd60051,  20'd57642,  20'd55342,
        20'd53146,  20'd51049,  20'd49045,  20'd47130,  20'd45300,  20'd43551,
        20'd41878,  20'd40278,  20'd38748,  20'd37283,  20'd35882,  20'd34540,
        20'd33255,  20'd32025,  20'd30846,  20'd29717,  20'd28635,  20'd27597,
        20'd26603,  20'd25649,  20'd24734,  20'd23856,  20'd23014,  20'd22206,
        20'd21431,  20'd20686,  20'd19970,  20'd19283,  20'd18623,  20'd17989,
        20'd17380,  20'd16794,  20'd16231,  20'd15689,  20'd15168,  20'd14667,
        20'd14185,  20'd13722,  20'd13275,  20'd12845,  20'd12431,  20'd12033,
        20'd11649,  20'd11279,  20'd10923,  20'd10580,  20'd10249,  20'd9930,
        20'd9623,   20'd9326,   20'd9040,   20'd8764,   20'd8498,   20'd8241,
        20'd7994,   20'd7754,   20'd7523,   20'd7300,   20'd7085,   20'd6877,
        20'd6676
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_SRCH,
        S_SPAN,
        S_FRAC
    } ntc_state_t;

    function automatic logic [EntryW-1:0] res_entry(input logic [TabIdxW-1:0] idx);
        logic [EntryW-1:0] val;
        val = '0;
        if (idx < TabIdxW'(StoredEntries))
        begin
            val = RES_TABLE[idx];
        end
        return val;
    endfunction

endpackage

>>> rtl/thermistor_adc_to_temperature.sv
// ----------------------------------------------------------------------------
// Thermistor ADC sample to temperature
// Sequence: a bit-serial multiply, a divide at one quotient bit per cycle,
// a binary search of the table, then an interpolated fraction and the strobe.
// Off the table the strobe follows the search; a rail reading strobes from idle.
// A start is taken only while idle; busy, if raised, stays high until the strobe cycle.
// The result strobe lasts one cycle and cannot be held off by the receiver.
// Reset clears the sequencer and sets the series resistor to 10000 ohms.
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature
    import ntc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TableEntriesDef,
    parameter int ADC_BITS      = AdcBitsDef
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [AdcW-1:0]         adc_sample,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CfgW-1:0]         cfg_data,
    output logic                    result_valid,
    output logic signed [TempW-1:0] temperature_centi,
    output logic                    in_range
);

    localparam int LIMIT = (TABLE_ENTRIES < StoredEntries) ? TABLE_ENTRIES : StoredEntries;
    localparam int IDX_W = $clog2(LIMIT);
    localparam int NUM_W = ProdBaseW + ADC_BITS;
    localparam int CNT_W = $clog2(ADC_BITS);
    localparam logic [ADC_BITS-1:0] FULL = {ADC_BITS{1'b1}};

    ntc_state_t state_reg, state_next;

    logic [CfgW-1:0]      sr_reg,      sr_next;
    logic                 rv_reg,      rv_next;
    logic [TempW-1:0]     temp_reg,    temp_next;
    logic                 inr_reg,     inr_next;
    logic [CNT_W-1:0]     cnt_reg,     cnt_next;
    logic [IDX_W-1:0]     probe_reg,   probe_next;

    logic [ADC_BITS-1:0]  adc_reg,     adc_next;
    logic [ADC_BITS-1:0]  den_reg,     den_next;
    logic [ProdBaseW-1:0] sr10_reg,    sr10_next;
    logic [NUM_W-1:0]     acc_reg,     acc_next;
    logic [NUM_W-1:0]     r_reg,       r_next;
    logic [IDX_W-1:0]     n_reg,       n_next;
    logic [FracNumW-1:0]  fnum_reg,    fnum_next;
    logic [FracNumW-1:0]  fden_reg,    fden_next;
    logic [FracQW-1:0]    q_reg,       q_next;

    logic [ADC_BITS-1:0]  adc_in;
    logic                 div_start;
    logic                 div_done;
    logic [NUM_W-1:0]     div_quo;

    logic [IDX_W-1:0]     cand;
    logic [EntryW-1:0]    cand_res;
    logic [TabIdxW-1:0]   n_idx;
    logic [EntryW-1:0]    hi_res;
    logic [EntryW-1:0]    lo_res;
    logic [EntryW-1:0]    d_val;
    logic [EntryW-1:0]    span_val;
    logic                 hit;
    logic [FracNumW-1:0]  d_ext;
    logic [FracQW-1:0]    q_step;
    logic [TempW-1:0]     base_temp;

    assign adc_in    = ADC_BITS'(adc_sample);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    ntc_div #(
        .NUM_W (NUM_W),
        .DEN_W (ADC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_next),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Table lookups: one probe during the search, the bracketing pair afterwards.
    assign cand     = n_reg | probe_reg;
    assign cand_res = res_entry(TabIdxW'(cand));
    assign n_idx    = TabIdxW'(n_reg);
    assign hi_res   = res_entry(n_idx);
    assign lo_res   = res_entry(n_idx + TabIdxW'(1));
    assign hit      = (n_reg != IDX_W'(LIMIT - 1)) && (NUM_W'(hi_res) >= r_reg);
    assign d_val    = hi_res - r_reg[EntryW-1:0];
    assign span_val = hi_res - lo_res;
    assign d_ext    = FracNumW'(d_val);
    assign q_step   = {q_reg[FracQW-2:0], (fnum_reg >= fden_reg)};
    assign base_temp = TempW'(TempBase) + TempW'(n_reg) * TempW'(CentiPerDegree);

    always_comb
    begin
        state_next = state_reg;
        sr_next    = sr_reg;
        rv_next    = 1'b0;
        temp_next  = temp_reg;
        inr_next   = inr_reg;
        cnt_next   = cnt_reg;
        probe_next = probe_reg;
        adc_next   = adc_reg;
        den_next   = den_reg;
        sr10_next  = sr10_reg;
        acc_next   = acc_reg;
        r_next     = r_reg;
        n_next     = n_reg;
        fnum_next  = fnum_reg;
        fden_next  = fden_reg;
        q_next     = q_reg;
        div_start  = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            sr_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (adc_in == '0 || adc_in >= FULL)
                    begin
                        rv_next   = 1'b1;
                        temp_next = '0;
                        inr_next  = 1'b0;
                    end
                    else
                    begin
                        adc_next   = adc_in;
                        den_next   = FULL - adc_in;
                        sr10_next  = (ProdBaseW'(sr_reg) << 3) + (ProdBaseW'(sr_reg) << 1);
                        acc_next   = '0;
                        cnt_next   = CNT_W'(ADC_BITS - 1);
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                // Shift-and-add over the sample, most significant bit first.
                acc_next = {acc_reg[NUM_W-2:0], 1'b0}
                         + (adc_reg[ADC_BITS-1] ? NUM_W'(sr10_reg) : '0);
                adc_next = {adc_reg[ADC_BITS-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    r_next     = div_quo;
                    n_next     = '0;
                    probe_next = IDX_W'(1) << (IDX_W - 1);
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                // Find the last index whose entry is above r; the table falls steadily,
                // so that index is found one index bit per cycle.
                if (cand <= IDX_W'(LIMIT - 1) && NUM_W'(cand_res) > r_reg)
                begin
                    n_next = cand;
                end
                probe_next = probe_reg >> 1;
                if (probe_reg[0])
                begin
                    state_next = S_SPAN;
                end
            end
            S_SPAN:
            begin
                if (!hit)
                begin
                    rv_next    = 1'b1;
                    temp_next  = '0;
                    inr_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else if (span_val == '0)
                begin
                    rv_next    = 1'b1;
                    temp_next  = base_temp;
                    inr_next   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // Rounded fraction: (200*d + span) / (2*span), below 128.
                    fnum_next  = (d_ext << 7) + (d_ext << 6) + (d_ext << 3)
                               + FracNumW'(span_val);
                    fden_next  = FracNumW'(span_val) << FracQW;
                    q_next     = '0;
                    cnt_next   = CNT_W'(FracQW - 1);
                    state_next = S_FRAC;
                end
            end
            S_FRAC:
            begin
                if (fnum_reg >= fden_reg)
                begin
                    fnum_next = fnum_reg - fden_reg;
                end
                fden_next = fden_reg >> 1;
                q_next    = q_step;
                if (cnt_reg == '0)
                begin
                    rv_next    = 1'b1;
                    temp_next  = base_temp + TempW'(q_step);
                    inr_next   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sr_reg    <= SeriesResReset;
            rv_reg    <= 1'b0;
            cnt_reg   <= '0;
            probe_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sr_reg    <= sr_next;
            rv_reg    <= rv_next;
            cnt_reg   <= cnt_next;
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        temp_reg <= temp_next;
        inr_reg  <= inr_next;
        adc_reg  <= adc_next;
        den_reg  <= den_next;
        sr10_reg <= sr10_next;
        acc_reg  <= acc_next;
        r_reg    <= r_next;
        n_reg    <= n_next;
        fnum_reg <= fnum_next;
        fden_reg <= fden_next;
        q_reg    <= q_next;
    end

    assign result_valid      = rv_reg;
    assign temperature_centi = $signed(temp_reg);
    assign in_range          = inr_reg;

    // A result word only appears once the sequencer is back at rest.
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while busy");

    a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !in_range) |-> (temperature_centi == '0))
        else $error("out-of-range result is not zero");

    a_out_span: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && in_range) |->
            (temperature_centi >= TempW'(TempBase) && temperature_centi <= TempW'(10000)))
        else $error("temperature outside the table span");

    a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> !result_valid)
        else $error("result strobe as a new word starts");

endmodule

>>> rtl/ntc_div.sv
// ----------------------------------------------------------------------------
// NTC restoring divider
// Bit-serial unsigned divider: one quotient bit per cycle, the dividend
// shifting out of the same register that the quotient shifts into.
// ----------------------------------------------------------------------------
module ntc_div
    import ntc_pkg::*;
#(
    parameter int NUM_W = ProdBaseW + AdcBitsDef,
    parameter int DEN_W = AdcBitsDef
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             run_reg,  run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [NUM_W-1:0] quo_reg,  quo_next;
    logic [DEN_W-1:0] rem_reg,  rem_next;
    logic [DEN_W-1:0] den_reg,  den_next;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             fits;

    assign rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign fits    = (rem_sh >= {1'b0, den_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            quo_next = dividend;
            den_next = divisor;
            rem_next = '0;
            cnt_next = CNT_W'(NUM_W - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
